@@ sv/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

	// Result queue depth between parser and output side (power of two, 2 or more)
	localparam int WSD_QUEUE_DEPTH = 2;

	// Frame opcodes with special handling
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	// 7-bit length codes
	localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
	localparam logic [6:0] LEN_EXT16     = 7'd126;

	// Extended length byte counts
	localparam logic [3:0] EXT_BYTES_16 = 4'd2;
	localparam logic [3:0] EXT_BYTES_64 = 4'd8;

	typedef enum logic [2:0] {
		EV_DATA  = 3'd0,
		EV_PONG  = 3'd1,
		EV_CLOSE = 3'd2,
		EV_ERROR = 3'd3,
		EV_EMPTY = 3'd4
	} event_t;

	typedef struct packed {
		event_t     ev;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       first;
		logic       last;
		logic       frame_last;
	} res_t;

	typedef struct packed {
		logic halted;
		logic push;
	} front_sts_t;

endpackage

@@ sv/wsd_front.sv @@
// Header parser and payload unmasker: one byte per beat, at most one result.
// Depends on wsd_pkg.
module wsd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         rx_byte,
	output logic               res_vld,
	output wsd_pkg::res_t      res,
	output wsd_pkg::front_sts_t sts
);
	import wsd_pkg::*;

	typedef enum logic [4:0] {
		PH_B0  = 5'b00001,
		PH_B1  = 5'b00010,
		PH_EXT = 5'b00100,
		PH_KEY = 5'b01000,
		PH_PAY = 5'b10000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic        fin_q, fin_n;
	logic [3:0]  opcode_q, opcode_n;
	logic [3:0]  ext_left_q, ext_left_n;
	logic [63:0] rem_q, rem_n;
	logic [31:0] key_q, key_n;
	logic [1:0]  idx_q, idx_n;
	logic        open_q, open_n;
	logic [3:0]  open_op_q, open_op_n;
	logic        first_q, first_n;
	logic        halted_q, halted_n;

	logic [3:0]  op_b;
	logic [6:0]  len_b;
	logic [3:0]  msg_op;
	logic [7:0]  kb;
	logic [63:0] rem_dec;
	logic        done;
	logic        is_data_op;

	assign op_b       = rx_byte[3:0];
	assign len_b      = rx_byte[6:0];
	assign msg_op     = (opcode_q != OP_CONT) ? opcode_q : open_op_q;
	assign rem_dec    = rem_q - 64'd1;
	assign done       = (rem_dec == 64'd0);
	assign is_data_op = (op_b != OP_CONT) && (op_b != OP_CLOSE) && (op_b != OP_PING);

	always_comb begin
		case (idx_q)
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n    = phase_q;
		fin_n      = fin_q;
		opcode_n   = opcode_q;
		ext_left_n = ext_left_q;
		rem_n      = rem_q;
		key_n      = key_q;
		idx_n      = idx_q;
		open_n     = open_q;
		open_op_n  = open_op_q;
		first_n    = first_q;
		halted_n   = halted_q;
		res_vld    = 1'b0;
		res        = '0;
		res.ev     = EV_DATA;

		if (take && !halted_q) begin
			case (phase_q)
				PH_B1: begin
					if (!rx_byte[7]) begin
						halted_n = 1'b1;
						res_vld  = 1'b1;
						res.ev   = EV_ERROR;
					end else begin
						idx_n = 2'd0;
						if (len_b <= LEN_SHORT_MAX) begin
							rem_n   = {57'd0, len_b};
							phase_n = PH_KEY;
						end else begin
							rem_n      = '0;
							ext_left_n = (len_b == LEN_EXT16) ? EXT_BYTES_16 : EXT_BYTES_64;
							phase_n    = PH_EXT;
						end
					end
				end
				PH_EXT: begin
					rem_n      = {rem_q[55:0], rx_byte};
					ext_left_n = ext_left_q - 4'd1;
					if (ext_left_q == 4'd1) begin
						phase_n = PH_KEY;
					end
				end
				PH_KEY: begin
					key_n = {key_q[23:0], rx_byte};
					idx_n = idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						phase_n = PH_PAY;
						if (rem_q == 64'd0) begin
							// empty frame ends on the last key byte
							phase_n = PH_B0;
							if (opcode_q == OP_CLOSE) begin
								halted_n         = 1'b1;
								res_vld          = 1'b1;
								res.ev           = EV_CLOSE;
								res.opcode       = OP_CLOSE;
								res.frame_last   = 1'b1;
							end else if (opcode_q == OP_PING) begin
								res_vld          = 1'b1;
								res.ev           = EV_PONG;
								res.opcode       = OP_PING;
								res.frame_last   = 1'b1;
							end else if (fin_q) begin
								first_n          = 1'b0;
								open_n           = 1'b0;
								res_vld          = 1'b1;
								res.ev           = EV_EMPTY;
								res.opcode       = msg_op;
								res.first        = first_q;
								res.last         = 1'b1;
								res.frame_last   = 1'b1;
							end
						end
					end
				end
				PH_PAY: begin
					idx_n = idx_q + 2'd1;
					rem_n = rem_dec;
					if (done) begin
						phase_n = PH_B0;
					end
					if (opcode_q == OP_CLOSE) begin
						if (done) begin
							halted_n       = 1'b1;
							res_vld        = 1'b1;
							res.ev         = EV_CLOSE;
							res.opcode     = OP_CLOSE;
							res.frame_last = 1'b1;
						end
					end else if (opcode_q == OP_PING) begin
						if (done) begin
							res_vld        = 1'b1;
							res.ev         = EV_PONG;
							res.opcode     = OP_PING;
							res.frame_last = 1'b1;
						end
					end else begin
						first_n        = 1'b0;
						if (done && fin_q) begin
							open_n = 1'b0;
						end
						res_vld        = 1'b1;
						res.ev         = EV_DATA;
						res.data       = rx_byte ^ kb;
						res.opcode     = msg_op;
						res.first      = first_q;
						res.last       = done && fin_q;
						res.frame_last = done;
					end
				end
				default: begin
					// header byte 0: RSV and continuation check, then FIN and opcode
					if ((rx_byte[6:4] != 3'd0) || ((op_b == OP_CONT) && !open_q)) begin
						halted_n = 1'b1;
						res_vld  = 1'b1;
						res.ev   = EV_ERROR;
					end else begin
						fin_n    = rx_byte[7];
						opcode_n = op_b;
						if (is_data_op) begin
							first_n = 1'b1;
							if (rx_byte[7]) begin
								open_n = 1'b0;
							end else begin
								open_n    = 1'b1;
								open_op_n = op_b;
							end
						end
						phase_n = PH_B1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_B0;
			fin_q      <= 1'b0;
			opcode_q   <= '0;
			ext_left_q <= '0;
			rem_q      <= '0;
			key_q      <= '0;
			idx_q      <= '0;
			open_q     <= 1'b0;
			open_op_q  <= '0;
			first_q    <= 1'b0;
			halted_q   <= 1'b0;
		end else begin
			phase_q    <= phase_n;
			fin_q      <= fin_n;
			opcode_q   <= opcode_n;
			ext_left_q <= ext_left_n;
			rem_q      <= rem_n;
			key_q      <= key_n;
			idx_q      <= idx_n;
			open_q     <= open_n;
			open_op_q  <= open_op_n;
			first_q    <= first_n;
			halted_q   <= halted_n;
		end
	end

	assign sts.halted = halted_q;
	assign sts.push   = res_vld;

endmodule

@@ sv/wsd_queue.sv @@
// Small result queue between the parser and the output channel.
// Depends on wsd_pkg for the result type.
module wsd_queue #(
	parameter int Depth = wsd_pkg::WSD_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wsd_pkg::res_t push_data,
	output logic          full,
	output logic          head_vld,
	input  logic          pop,
	output wsd_pkg::res_t head
);
	import wsd_pkg::*;

	localparam int PtrW = $clog2(Depth);

	res_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   count_q;

	assign full     = (count_q == Depth[PtrW:0]);
	assign head_vld = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/websocket_frame_deframer.sv @@
// WebSocket client-to-server deframer: byte in, unmasked payload and events out.
// Results are registered in the result queue and shown on the output from its head.
// Throughput: one byte per cycle; rx_stall rises only when the result queue
// (QDepth entries) is full because results are not being taken.
// Reset: arst_n clears parser state, halt flag and queue at once; no clearing pass.
module websocket_frame_deframer #(
	parameter int QDepth = wsd_pkg::WSD_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// input byte stream
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	// result stream
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] event_res,
	output logic [7:0] data_byte,
	output logic [3:0] message_opcode,
	output logic       message_first,
	output logic       message_last,
	output logic       frame_last
);
	import wsd_pkg::*;

	logic       take;
	logic       pop;
	logic       q_full;
	logic       res_vld;
	res_t       res;
	res_t       head;
	front_sts_t sts;

	// A beat is taken whenever the queue has room; every byte yields at most
	// one result, so room for one entry is all the front part needs.
	assign rx_stall = q_full;
	assign take     = rx_valid && !rx_stall;
	assign pop      = res_valid && !res_stall;

	// Front part: header parse, length and key capture, payload unmasking,
	// fragment tracking and the halt after close or error.
	wsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.res_vld (res_vld),
		.res     (res),
		.sts     (sts)
	);

	// Back part: result queue whose head drives the output channel, so the
	// two channels stall independently.
	wsd_queue #(
		.Depth (QDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_vld),
		.push_data (res),
		.full      (q_full),
		.head_vld  (res_valid),
		.pop       (pop),
		.head      (head)
	);

	assign event_res      = head.ev;
	assign data_byte      = head.data;
	assign message_opcode = head.opcode;
	assign message_first  = head.first;
	assign message_last   = head.last;
	assign frame_last     = head.frame_last;

	// Halt only follows a close or error result from the previous beat.
	a_halt_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sts.halted) |-> $past(sts.push && (res.ev == EV_ERROR || res.ev == EV_CLOSE)))
		else $error("halt without close or error result");

	// Once halted the parser produces nothing.
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		sts.halted |-> !sts.push)
		else $error("result produced while halted");

	// Only payload beats carry data; errors never close a frame.
	a_res_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((event_res == EV_DATA) || (data_byte == 8'd0))
		&& ((event_res != EV_ERROR) || !frame_last))
		else $error("malformed result at output");

endmodule
